[hw/rtl/alurf_pkg.sv]
`default_nettype none
package alurf_pkg;

	// sizes of the register file and datapath
	localparam int NUM_REGS    = 8;
	localparam int DATA_WIDTH  = 32;
	localparam int REG_IDX_W   = $clog2(NUM_REGS);
	localparam int FIELD_IDX_W = 3;
	localparam int SHIFT_W     = 5;
	localparam int OPC_W       = 4;

	// front-to-back queue depth (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// request opcodes
	localparam logic [OPC_W-1:0] REQ_ADD = 4'd0;
	localparam logic [OPC_W-1:0] REQ_AND = 4'd1;
	localparam logic [OPC_W-1:0] REQ_LSR = 4'd2;
	localparam logic [OPC_W-1:0] REQ_LSL = 4'd3;
	localparam logic [OPC_W-1:0] REQ_NOT = 4'd4;
	localparam logic [OPC_W-1:0] REQ_ORR = 4'd5;
	localparam logic [OPC_W-1:0] REQ_SUB = 4'd6;
	localparam logic [OPC_W-1:0] REQ_XOR = 4'd7;
	localparam logic [OPC_W-1:0] REQ_MOV = 4'd8;
	localparam logic [OPC_W-1:0] REQ_CMP = 4'd9;
	localparam logic [OPC_W-1:0] REQ_TST = 4'd10;

	typedef logic [REG_IDX_W-1:0]  idx_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	// function the back end carries out
	typedef enum logic [3:0] {
		FN_ADD,
		FN_AND,
		FN_LSR,
		FN_LSL,
		FN_NOT,
		FN_ORR,
		FN_SUB,
		FN_XOR,
		FN_MOV,
		FN_NONE
	} alu_fn_t;

	// classified item as held in the queue
	typedef struct packed {
		alu_fn_t             fn;
		logic                wr;
		logic                upd_nz;
		logic                upd_c;
		logic                upd_v;
		idx_t                dest;
		idx_t                raddr1;
		idx_t                raddr2;
		logic [SHIFT_W-1:0]  sh;
		word_t               imm;
	} qent_t;

	// register index folded into the file
	function automatic idx_t reg_index(input logic [FIELD_IDX_W-1:0] f);
		logic [FIELD_IDX_W-1:0] m;
		m = FIELD_IDX_W'(int'(f) % NUM_REGS);
		return idx_t'(m);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/alurf_front.sv]
`default_nettype none
module alurf_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [alurf_pkg::OPC_W-1:0]        req_type,
	input  wire logic                               set_flags,
	input  wire logic [alurf_pkg::FIELD_IDX_W-1:0]  dest_reg,
	input  wire logic [alurf_pkg::FIELD_IDX_W-1:0]  src_a_reg,
	input  wire logic [alurf_pkg::FIELD_IDX_W-1:0]  src_b_reg,
	input  wire logic [alurf_pkg::SHIFT_W-1:0]      shift_amount,
	input  wire logic [alurf_pkg::DATA_WIDTH-1:0]   immediate,
	output alurf_pkg::qent_t                        head,
	output logic                                    head_vld,
	input  wire logic                               head_pop
);
	import alurf_pkg::*;

	qent_t               ent;
	idx_t                d_idx;
	idx_t                a_idx;
	idx_t                b_idx;
	logic                acc;
	qent_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign d_idx = reg_index(dest_reg);
	assign a_idx = reg_index(src_a_reg);
	assign b_idx = reg_index(src_b_reg);

	// classify the incoming item
	always_comb begin
		ent        = '0;
		ent.fn     = FN_NONE;
		ent.dest   = d_idx;
		ent.raddr1 = a_idx;
		ent.raddr2 = b_idx;
		ent.sh     = shift_amount;
		ent.imm    = immediate;
		unique case (req_type)
			REQ_ADD, REQ_SUB: begin
				ent.fn     = (req_type == REQ_ADD) ? FN_ADD : FN_SUB;
				ent.wr     = 1'b1;
				ent.upd_nz = set_flags;
				ent.upd_c  = set_flags;
				ent.upd_v  = set_flags;
			end
			REQ_LSR, REQ_LSL: begin
				ent.fn     = (req_type == REQ_LSR) ? FN_LSR : FN_LSL;
				ent.wr     = 1'b1;
				ent.upd_nz = set_flags;
				ent.upd_c  = set_flags && (shift_amount != '0);
			end
			REQ_AND: begin
				ent.fn     = FN_AND;
				ent.wr     = 1'b1;
				ent.upd_nz = set_flags;
			end
			REQ_NOT: begin
				ent.fn     = FN_NOT;
				ent.wr     = 1'b1;
				ent.upd_nz = set_flags;
			end
			REQ_ORR: begin
				ent.fn     = FN_ORR;
				ent.wr     = 1'b1;
				ent.upd_nz = set_flags;
			end
			REQ_XOR: begin
				ent.fn     = FN_XOR;
				ent.wr     = 1'b1;
				ent.upd_nz = set_flags;
			end
			REQ_MOV: begin
				ent.fn     = FN_MOV;
				ent.wr     = 1'b1;
				ent.upd_nz = 1'b1;
			end
			REQ_CMP: begin
				ent.fn     = FN_SUB;
				ent.upd_nz = 1'b1;
				ent.upd_c  = 1'b1;
				ent.upd_v  = 1'b1;
				ent.raddr1 = d_idx;
				ent.raddr2 = a_idx;
			end
			REQ_TST: begin
				ent.fn     = FN_AND;
				ent.upd_nz = 1'b1;
				ent.raddr1 = d_idx;
				ent.raddr2 = a_idx;
			end
			default: begin
				ent.fn = FN_NONE;
			end
		endcase
	end

	// queue status
	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rptr_q];
	assign acc      = push && !full;

	// queue storage
	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wptr_q] <= ent;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (acc) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (head_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (acc && !head_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!acc && head_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/alurf_back.sv]
`default_nettype none
module alurf_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire alurf_pkg::qent_t                    head,
	input  wire logic                                head_vld,
	output logic                                     head_pop,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic                                     wrote_reg,
	output logic [alurf_pkg::FIELD_IDX_W-1:0]        written_index,
	output logic [alurf_pkg::DATA_WIDTH-1:0]         result_value,
	output logic                                     flag_n,
	output logic                                     flag_z,
	output logic                                     flag_c,
	output logic                                     flag_v
);
	import alurf_pkg::*;

	// register file with per-entry valid bits (invalid reads as zero)
	word_t                 rf_q [NUM_REGS];
	logic [NUM_REGS-1:0]   rf_vld_q;

	// read stage
	logic                  vld_s1;
	qent_t                 ent_s1;
	word_t                 rd1_s1;
	word_t                 rd2_s1;
	logic                  rd1_ok_s1;
	logic                  rd2_ok_s1;
	logic                  fwd_vld_s1;
	idx_t                  fwd_idx_s1;
	word_t                 fwd_data_s1;

	// result register
	logic                  vld_s2;
	logic                  wr_s2;
	idx_t                  idx_s2;
	word_t                 res_s2;

	// architectural flags
	logic                  flag_n_q;
	logic                  flag_z_q;
	logic                  flag_c_q;
	logic                  flag_v_q;

	logic                  exec_fire;
	logic                  load_s1;
	word_t                 op1;
	word_t                 op2;
	logic [DATA_WIDTH:0]   sum;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH:0]   shl;
	logic [DATA_WIDTH:0]   shr;
	word_t                 res;
	logic                  c_new;
	logic                  v_new;
	logic                  n_nxt;
	logic                  z_nxt;
	logic                  c_nxt;
	logic                  v_nxt;

	// stage handshakes
	assign exec_fire = vld_s1 && (!vld_s2 || pop);
	assign load_s1   = head_vld && (!vld_s1 || exec_fire);
	assign head_pop  = load_s1;

	// operand select with bypass of the write made alongside the read
	always_comb begin
		op1 = rd1_ok_s1 ? rd1_s1 : '0;
		op2 = rd2_ok_s1 ? rd2_s1 : '0;
		if (fwd_vld_s1 && (fwd_idx_s1 == ent_s1.raddr1)) begin
			op1 = fwd_data_s1;
		end
		if (fwd_vld_s1 && (fwd_idx_s1 == ent_s1.raddr2)) begin
			op2 = fwd_data_s1;
		end
	end

	// datapath
	assign sum  = {1'b0, op1} + {1'b0, op2};
	assign diff = {1'b0, op1} - {1'b0, op2};
	assign shl  = {1'b0, op1} << ent_s1.sh;
	assign shr  = {op1, 1'b0} >> ent_s1.sh;

	always_comb begin
		res   = '0;
		c_new = flag_c_q;
		v_new = flag_v_q;
		unique case (ent_s1.fn)
			FN_ADD: begin
				res   = sum[DATA_WIDTH-1:0];
				c_new = sum[DATA_WIDTH];
				v_new = (op1[DATA_WIDTH-1] == op2[DATA_WIDTH-1])
					&& (sum[DATA_WIDTH-1] != op1[DATA_WIDTH-1]);
			end
			FN_SUB: begin
				res   = diff[DATA_WIDTH-1:0];
				c_new = !diff[DATA_WIDTH];
				v_new = (op1[DATA_WIDTH-1] != op2[DATA_WIDTH-1])
					&& (diff[DATA_WIDTH-1] != op1[DATA_WIDTH-1]);
			end
			FN_LSR: begin
				res   = shr[DATA_WIDTH:1];
				c_new = shr[0];
			end
			FN_LSL: begin
				res   = shl[DATA_WIDTH-1:0];
				c_new = shl[DATA_WIDTH];
			end
			FN_AND: res = op1 & op2;
			FN_NOT: res = ~op1;
			FN_ORR: res = op1 | op2;
			FN_XOR: res = op1 ^ op2;
			FN_MOV: res = ent_s1.imm;
			FN_NONE: res = '0;
			default: res = '0;
		endcase
	end

	// flags after this item
	assign n_nxt = ent_s1.upd_nz ? res[DATA_WIDTH-1] : flag_n_q;
	assign z_nxt = ent_s1.upd_nz ? (res == '0) : flag_z_q;
	assign c_nxt = ent_s1.upd_c ? c_new : flag_c_q;
	assign v_nxt = ent_s1.upd_v ? v_new : flag_v_q;

	// register file write and registered reads
	always_ff @(posedge clk) begin
		if (exec_fire && ent_s1.wr) begin
			rf_q[ent_s1.dest] <= res;
		end
		if (load_s1) begin
			rd1_s1 <= rf_q[head.raddr1];
			rd2_s1 <= rf_q[head.raddr2];
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			ent_s1      <= head;
			fwd_idx_s1  <= ent_s1.dest;
			fwd_data_s1 <= res;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			wr_s2  <= ent_s1.wr;
			idx_s2 <= ent_s1.wr ? ent_s1.dest : '0;
			res_s2 <= res;
		end
	end

	// control state, valid bits and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q   <= '0;
			vld_s1     <= 1'b0;
			rd1_ok_s1  <= 1'b0;
			rd2_ok_s1  <= 1'b0;
			fwd_vld_s1 <= 1'b0;
			vld_s2     <= 1'b0;
			flag_n_q   <= 1'b0;
			flag_z_q   <= 1'b0;
			flag_c_q   <= 1'b0;
			flag_v_q   <= 1'b0;
		end else begin
			if (load_s1) begin
				vld_s1     <= 1'b1;
				rd1_ok_s1  <= rf_vld_q[head.raddr1];
				rd2_ok_s1  <= rf_vld_q[head.raddr2];
				fwd_vld_s1 <= exec_fire && ent_s1.wr;
			end else if (exec_fire) begin
				vld_s1 <= 1'b0;
			end
			if (exec_fire) begin
				vld_s2   <= 1'b1;
				flag_n_q <= n_nxt;
				flag_z_q <= z_nxt;
				flag_c_q <= c_nxt;
				flag_v_q <= v_nxt;
				if (ent_s1.wr) begin
					rf_vld_q[ent_s1.dest] <= 1'b1;
				end
			end else if (pop) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// flags are captured with the result
	logic fn_s2;
	logic fz_s2;
	logic fc_s2;
	logic fv_s2;

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			fn_s2 <= n_nxt;
			fz_s2 <= z_nxt;
			fc_s2 <= c_nxt;
			fv_s2 <= v_nxt;
		end
	end

	// result ports
	assign empty         = !vld_s2;
	assign wrote_reg     = wr_s2;
	assign written_index = FIELD_IDX_W'(idx_s2);
	assign result_value  = res_s2;
	assign flag_n        = fn_s2;
	assign flag_z        = fz_s2;
	assign flag_c        = fc_s2;
	assign flag_v        = fv_s2;

endmodule
`default_nettype wire

[hw/rtl/alu_register_file_with_flags.sv]
// an item pushed passes through the queue, the register read stage and execute
//   into the result register
// throughput: one item per cycle while pop is held high; a withheld pop stalls execute
// reset: queue and pipeline empty, all registers and N, Z, C, V flags read zero
`default_nettype none
module alu_register_file_with_flags (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [alurf_pkg::OPC_W-1:0]        req_type,
	input  wire logic                               set_flags,
	input  wire logic [alurf_pkg::FIELD_IDX_W-1:0]  dest_reg,
	input  wire logic [alurf_pkg::FIELD_IDX_W-1:0]  src_a_reg,
	input  wire logic [alurf_pkg::FIELD_IDX_W-1:0]  src_b_reg,
	input  wire logic [alurf_pkg::SHIFT_W-1:0]      shift_amount,
	input  wire logic [alurf_pkg::DATA_WIDTH-1:0]   immediate,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic                                    wrote_reg,
	output logic [alurf_pkg::FIELD_IDX_W-1:0]       written_index,
	output logic [alurf_pkg::DATA_WIDTH-1:0]        result_value,
	output logic                                    flag_n,
	output logic                                    flag_z,
	output logic                                    flag_c,
	output logic                                    flag_v
);
	import alurf_pkg::*;

	qent_t head;
	logic  head_vld;
	logic  head_pop;

	// decode and queue
	alurf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.set_flags    (set_flags),
		.dest_reg     (dest_reg),
		.src_a_reg    (src_a_reg),
		.src_b_reg    (src_b_reg),
		.shift_amount (shift_amount),
		.immediate    (immediate),
		.head         (head),
		.head_vld     (head_vld),
		.head_pop     (head_pop)
	);

	// register file, execute and result register
	alurf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_vld      (head_vld),
		.head_pop      (head_pop),
		.empty         (empty),
		.pop           (pop),
		.wrote_reg     (wrote_reg),
		.written_index (written_index),
		.result_value  (result_value),
		.flag_n        (flag_n),
		.flag_z        (flag_z),
		.flag_c        (flag_c),
		.flag_v        (flag_v)
	);

endmodule
`default_nettype wire

[tb/sv/alu_register_file_with_flags_tb.sv]
`timescale 1ns / 1ps
module alu_register_file_with_flags_tb;
	import alurf_pkg::*;

	// opcodes the block leaves undefined
	localparam logic [OPC_W-1:0] REQ_UNDEF_LO = 4'd11;
	localparam logic [OPC_W-1:0] REQ_UNDEF_HI = 4'd15;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 160;
	localparam int NUM_PHASES = 4;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [OPC_W-1:0]       op;
		logic                   sf;
		logic [FIELD_IDX_W-1:0] rd;
		logic [FIELD_IDX_W-1:0] ra;
		logic [FIELD_IDX_W-1:0] rb;
		logic [SHIFT_W-1:0]     sh;
		word_t                  imm;
	} instr_t;

	typedef struct packed {
		logic                   wr;
		logic [FIELD_IDX_W-1:0] widx;
		word_t                  val;
		logic                   n;
		logic                   z;
		logic                   c;
		logic                   v;
	} retire_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   pop = 1'b0;
	logic [OPC_W-1:0]       req_type = '0;
	logic                   set_flags = 1'b0;
	logic [FIELD_IDX_W-1:0] dest_reg = '0;
	logic [FIELD_IDX_W-1:0] src_a_reg = '0;
	logic [FIELD_IDX_W-1:0] src_b_reg = '0;
	logic [SHIFT_W-1:0]     shift_amount = '0;
	word_t                  immediate = '0;
	logic                   full;
	logic                   empty;
	logic                   wrote_reg;
	logic [FIELD_IDX_W-1:0] written_index;
	word_t                  result_value;
	logic                   flag_n;
	logic                   flag_z;
	logic                   flag_c;
	logic                   flag_v;

	// architectural state tracked alongside the block
	word_t arch_regs [NUM_REGS] = '{default: '0};
	logic  arch_n = 1'b0;
	logic  arch_z = 1'b0;
	logic  arch_c = 1'b0;
	logic  arch_v = 1'b0;

	instr_t  pending_instrs [$];
	retire_t expected_retires [$];
	int      error_count = 0;
	int      stall_cycles = 0;
	int      tx_idle_pct = 0;
	int      rx_stall_pct = 0;
	bit      took_item = 1'b0;

	alu_register_file_with_flags dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.set_flags(set_flags),
		.dest_reg(dest_reg),
		.src_a_reg(src_a_reg),
		.src_b_reg(src_b_reg),
		.shift_amount(shift_amount),
		.immediate(immediate),
		.empty(empty),
		.pop(pop),
		.wrote_reg(wrote_reg),
		.written_index(written_index),
		.result_value(result_value),
		.flag_n(flag_n),
		.flag_z(flag_z),
		.flag_c(flag_c),
		.flag_v(flag_v)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// x - y with no-borrow carry and signed overflow
	function automatic word_t sub_with_flags(input word_t x, input word_t y,
			output logic no_borrow, output logic ovf);
		word_t d;
		d = x - y;
		no_borrow = (x >= y);
		ovf = (x[DATA_WIDTH-1] != y[DATA_WIDTH-1]) && (d[DATA_WIDTH-1] != x[DATA_WIDTH-1]);
		return d;
	endfunction

	// retire one instruction against the tracked state
	function automatic retire_t execute_instr(input instr_t it);
		word_t               a;
		word_t               b;
		word_t               r;
		logic [DATA_WIDTH:0] sum;
		logic                wr;
		logic                setf;
		logic                cf;
		logic                vf;
		logic                has_c;
		logic                has_v;
		retire_t             o;
		a = arch_regs[it.ra];
		b = arch_regs[it.rb];
		r = '0;
		wr = 1'b0;
		setf = 1'b0;
		cf = arch_c;
		vf = arch_v;
		has_c = 1'b0;
		has_v = 1'b0;
		case (it.op)
			REQ_ADD: begin
				sum = {1'b0, a} + {1'b0, b};
				r = sum[DATA_WIDTH-1:0];
				cf = sum[DATA_WIDTH];
				vf = (a[DATA_WIDTH-1] == b[DATA_WIDTH-1]) && (r[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
				has_c = 1'b1;
				has_v = 1'b1;
			end
			REQ_AND: r = a & b;
			REQ_LSR: begin
				r = a >> it.sh;
				// carry is the last bit out; zero shift keeps it
				if (it.sh != 0) begin
					cf = a[it.sh - 1];
					has_c = 1'b1;
				end
			end
			REQ_LSL: begin
				r = a << it.sh;
				if (it.sh != 0) begin
					cf = a[DATA_WIDTH - it.sh];
					has_c = 1'b1;
				end
			end
			REQ_NOT: r = ~a;
			REQ_ORR: r = a | b;
			REQ_SUB: begin
				r = sub_with_flags(a, b, cf, vf);
				has_c = 1'b1;
				has_v = 1'b1;
			end
			REQ_XOR: r = a ^ b;
			REQ_MOV: r = it.imm;
			REQ_CMP: begin
				r = sub_with_flags(arch_regs[it.rd], a, cf, vf);
				has_c = 1'b1;
				has_v = 1'b1;
			end
			REQ_TST: r = arch_regs[it.rd] & a;
			default: ;
		endcase
		// which instructions write and which touch the flags
		if (it.op <= REQ_XOR) begin
			wr = 1'b1;
			setf = it.sf;
		end else if (it.op == REQ_MOV) begin
			wr = 1'b1;
			setf = 1'b1;
			has_c = 1'b0;
			has_v = 1'b0;
		end else if (it.op == REQ_CMP || it.op == REQ_TST) begin
			setf = 1'b1;
		end
		if (setf) begin
			arch_n = r[DATA_WIDTH-1];
			arch_z = (r == '0);
			if (has_c)
				arch_c = cf;
			if (has_v)
				arch_v = vf;
		end
		if (wr)
			arch_regs[it.rd] = r;
		o.wr = wr;
		o.widx = wr ? it.rd : '0;
		o.val = r;
		o.n = arch_n;
		o.z = arch_z;
		o.c = arch_c;
		o.v = arch_v;
		return o;
	endfunction

	function automatic instr_t make_instr(input logic [OPC_W-1:0] op, input bit sf,
			input int rd, input int ra, input int rb, input int sh, input word_t imm);
		instr_t it;
		it.op = op;
		it.sf = sf;
		it.rd = FIELD_IDX_W'(rd);
		it.ra = FIELD_IDX_W'(ra);
		it.rb = FIELD_IDX_W'(rb);
		it.sh = SHIFT_W'(sh);
		it.imm = imm;
		return it;
	endfunction

	// mostly defined opcodes, extra movs to refresh registers, a few undefined
	function automatic instr_t random_instr();
		instr_t it;
		int     pick;
		pick = $urandom_range(99);
		if (pick < 5)
			it.op = OPC_W'($urandom_range(REQ_UNDEF_HI, REQ_UNDEF_LO));
		else if (pick < 25)
			it.op = REQ_MOV;
		else
			it.op = OPC_W'($urandom_range(REQ_TST, REQ_ADD));
		it.sf = 1'($urandom_range(1));
		it.rd = FIELD_IDX_W'($urandom_range(NUM_REGS - 1));
		it.ra = FIELD_IDX_W'($urandom_range(NUM_REGS - 1));
		it.rb = FIELD_IDX_W'($urandom_range(NUM_REGS - 1));
		case ($urandom_range(7))
			0: it.sh = '0;
			1: it.sh = SHIFT_W'(1);
			2: it.sh = '1;
			default: it.sh = SHIFT_W'($urandom_range(DATA_WIDTH - 1));
		endcase
		case ($urandom_range(7))
			0: it.imm = '0;
			1: it.imm = '1;
			2: it.imm = word_t'(1) << (DATA_WIDTH - 1);
			3: it.imm = ~(word_t'(1) << (DATA_WIDTH - 1));
			4: it.imm = word_t'(1);
			default: it.imm = word_t'($urandom);
		endcase
		return it;
	endfunction

	task automatic check_field(input string name, input word_t want, input word_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// drive the next item at the falling edge, hold it until taken
	always @(negedge clk) begin
		instr_t nxt;
		if (arst_n) begin
			if (!push || took_item) begin
				if (pending_instrs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = pending_instrs.pop_front();
					req_type <= nxt.op;
					set_flags <= nxt.sf;
					dest_reg <= nxt.rd;
					src_a_reg <= nxt.ra;
					src_b_reg <= nxt.rb;
					shift_amount <= nxt.sh;
					immediate <= nxt.imm;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// accept items and results at the rising edge
	always @(posedge clk) begin
		retire_t got;
		retire_t want;
		if (arst_n) begin
			took_item = push && !full;
			if (took_item)
				expected_retires.push_back(execute_instr(instr_t'({req_type, set_flags,
					dest_reg, src_a_reg, src_b_reg, shift_amount, immediate})));
			if (pop && !empty) begin
				got = {wrote_reg, written_index, result_value, flag_n, flag_z, flag_c, flag_v};
				if (expected_retires.size() == 0) begin
					$display("%0t: result with no item outstanding, actual %h", $time, got);
					error_count++;
				end else begin
					want = expected_retires.pop_front();
					check_field("wrote_reg", word_t'(want.wr), word_t'(got.wr));
					check_field("written_index", word_t'(want.widx), word_t'(got.widx));
					check_field("result_value", want.val, got.val);
					check_field("flag_n", word_t'(want.n), word_t'(got.n));
					check_field("flag_z", word_t'(want.z), word_t'(got.z));
					check_field("flag_c", word_t'(want.c), word_t'(got.c));
					check_field("flag_v", word_t'(want.v), word_t'(got.v));
				end
			end
			// watchdog on cycles with work outstanding and nothing moving
			if (took_item || (pop && !empty) || (pending_instrs.size() == 0 && !push
					&& expected_retires.size() == 0))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, stall_cycles);
				$display("alu_register_file_with_flags_tb failed");
				$finish;
			end
		end
	end

	// reset, then phases of directed and random items
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			@(posedge clk);
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
					// load extreme values
					pending_instrs.push_back(make_instr(REQ_MOV, 0, 0, 0, 0, 0, 32'h8000_0000));
					pending_instrs.push_back(make_instr(REQ_MOV, 1, 1, 0, 0, 0, 32'hFFFF_FFFF));
					pending_instrs.push_back(make_instr(REQ_MOV, 0, 2, 0, 0, 0, 32'h0000_0001));
					pending_instrs.push_back(make_instr(REQ_MOV, 0, 3, 0, 0, 0, 32'h0000_0000));
					pending_instrs.push_back(make_instr(REQ_MOV, 0, 6, 0, 0, 0, 32'h7FFF_FFFF));
					// add: carry to zero, carry with overflow, overflow only, no flags
					pending_instrs.push_back(make_instr(REQ_ADD, 1, 4, 1, 2, 0, '0));
					pending_instrs.push_back(make_instr(REQ_ADD, 1, 5, 0, 0, 0, '0));
					pending_instrs.push_back(make_instr(REQ_ADD, 1, 7, 6, 2, 0, '0));
					pending_instrs.push_back(make_instr(REQ_ADD, 0, 4, 1, 1, 0, '0));
					// subtract: borrow, then signed overflow
					pending_instrs.push_back(make_instr(REQ_SUB, 1, 4, 3, 2, 0, '0));
					pending_instrs.push_back(make_instr(REQ_SUB, 1, 5, 0, 2, 0, '0));
					// logic ops keep carry and overflow
					pending_instrs.push_back(make_instr(REQ_AND, 1, 4, 1, 0, 0, '0));
					pending_instrs.push_back(make_instr(REQ_ORR, 1, 4, 3, 3, 0, '0));
					pending_instrs.push_back(make_instr(REQ_XOR, 1, 4, 1, 6, 0, '0));
					pending_instrs.push_back(make_instr(REQ_NOT, 1, 4, 1, 0, 0, '0));
					// shifts: largest count, zero count keeps carry, sign bit in
					pending_instrs.push_back(make_instr(REQ_LSR, 1, 4, 1, 0, 31, '0));
					pending_instrs.push_back(make_instr(REQ_LSR, 1, 4, 0, 0, 0, '0));
					pending_instrs.push_back(make_instr(REQ_LSL, 1, 4, 2, 0, 31, '0));
					pending_instrs.push_back(make_instr(REQ_LSL, 1, 4, 1, 0, 1, '0));
					// compare and test never write
					pending_instrs.push_back(make_instr(REQ_CMP, 0, 3, 2, 0, 0, '0));
					pending_instrs.push_back(make_instr(REQ_CMP, 0, 0, 2, 0, 0, '0));
					pending_instrs.push_back(make_instr(REQ_CMP, 1, 1, 1, 0, 0, '0));
					pending_instrs.push_back(make_instr(REQ_TST, 0, 1, 0, 0, 0, '0));
					pending_instrs.push_back(make_instr(REQ_TST, 0, 3, 1, 0, 0, '0));
					// undefined opcodes change nothing
					pending_instrs.push_back(make_instr(REQ_UNDEF_LO, 0, 0, 0, 0, 0, '0));
					pending_instrs.push_back(make_instr(REQ_UNDEF_HI, 1, 7, 7, 7, 31, '1));
					// destination is also both sources
					pending_instrs.push_back(make_instr(REQ_ADD, 1, 1, 1, 1, 0, '0));
				end
				1: begin
					tx_idle_pct = 83;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 83;
				end
				default: begin
					tx_idle_pct = 22;
					rx_stall_pct = 22;
				end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				pending_instrs.push_back(random_instr());
			do
				@(negedge clk);
			while (pending_instrs.size() != 0 || push || expected_retires.size() != 0);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_retires.size() == 0)
			$display("alu_register_file_with_flags_tb passed");
		else
			$display("alu_register_file_with_flags_tb failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/alurf_pkg.sv
hw/rtl/alurf_front.sv
hw/rtl/alurf_back.sv
hw/rtl/alu_register_file_with_flags.sv
tb/sv/alu_register_file_with_flags_tb.sv
